// File: src/mfrp_pkg.sv
// Package for the media frame RTP packetizer.
// Holds the shared types, the header constants and the register map.
// It depends on nothing else.
package mfrp_pkg;

  // Header constants.
  localparam logic [31:0] MAGIC_WORD   = 32'h3031_6364;
  localparam logic [7:0]  VERSION_BYTE = 8'h81;
  localparam logic [4:0]  VIDEO_HDR_LAST = 5'd29;
  localparam logic [4:0]  AUDIO_HDR_LAST = 5'd25;
  localparam logic [4:0]  TAIL_START     = 5'd24;
  localparam logic [4:0]  AUDIO_SKIP     = 5'd4;

  // NAL unit kinds that decide the frame type.
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SPS     = 5'd7;

  // Data type codes of the header's upper nibble.
  localparam logic [2:0] TYPE_I     = 3'd0;
  localparam logic [2:0] TYPE_P     = 3'd1;
  localparam logic [2:0] TYPE_AUDIO = 3'd3;
  localparam logic [2:0] TYPE_OTHER = 3'd4;

  // Subpacket marks.
  localparam logic [1:0] MARK_ONLY   = 2'd0;
  localparam logic [1:0] MARK_FIRST  = 2'd1;
  localparam logic [1:0] MARK_LAST   = 2'd2;
  localparam logic [1:0] MARK_MIDDLE = 2'd3;

  // Register map and reset values.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIM_NUMBER    = 3'd0,
    REG_CHANNEL       = 3'd1,
    REG_VIDEO_PT      = 3'd2,
    REG_AUDIO_PT      = 3'd3,
    REG_BODY_LEN      = 3'd4
  } cfg_reg_t;

  localparam logic [47:0] SIM_RESET      = 48'd0;
  localparam logic [7:0]  CHANNEL_RESET  = 8'd1;
  localparam logic [6:0]  VIDEO_PT_RESET = 7'd98;
  localparam logic [6:0]  AUDIO_PT_RESET = 7'd19;
  localparam logic [9:0]  BODY_LEN_RESET = 10'd950;

  // Depth of the queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [47:0] sim_number;
    logic [7:0]  logical_channel;
    logic [6:0]  video_pt;
    logic [6:0]  audio_pt;
    logic [9:0]  body_len;
  } cfg_t;

  // One classified byte: the data byte, and the packet header if one opens here.
  typedef struct packed {
    logic [7:0]  data;
    logic        eop;
    logic        hdr;
    logic        audio;
    logic [7:0]  pt_byte;
    logic [15:0] serial;
    logic [7:0]  type_byte;
    logic [31:0] frame_time;
    logic [15:0] iframe_int;
    logic [15:0] frame_int;
    logic [9:0]  plen;
  } cmd_t;

endpackage

// File: src/media_frame_rtp_packetizer.sv
// Top level of the media frame RTP packetizer: configuration registers,
// front end, command queue and back end. Depends on mfrp_pkg and the mfrp_ modules.
//
// Frames enter one byte per request, and each byte leaves as one result,
// preceded by a 30-byte video or 26-byte audio header when it opens a packet
// of at most body_len bytes (one when body_len is zero). The output register
// sends one byte a cycle while out_ready allows and commands are queued, and a
// byte that opens a packet leaves after its header bytes. A two-entry command
// queue lets the front end take the next bytes while a header goes out. Bytes
// outside a frame are dropped and give no result. Configuration writes are
// taken at once (cfg_ready is always high) and must come while no request is
// in flight.
module media_frame_rtp_packetizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_first_of_frame,
  input  logic                           in_is_audio,
  input  logic [19:0]                    in_frame_len,
  input  logic [31:0]                    in_frame_time,
  input  logic [31:0]                    in_now_ms,
  input  logic [4:0]                     in_nal_kind,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_end_of_packet,
  output logic                           out_end_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfrp_pkg::*;

  logic [47:0] sim_r;
  logic [7:0]  channel_r;
  logic [6:0]  video_pt_r;
  logic [6:0]  audio_pt_r;
  logic [9:0]  body_len_r;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;

  assign cfg_ready = 1'b1;
  assign cfg = '{sim_number: sim_r, logical_channel: channel_r, video_pt: video_pt_r,
                 audio_pt: audio_pt_r, body_len: body_len_r};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sim_r      <= SIM_RESET;
      channel_r  <= CHANNEL_RESET;
      video_pt_r <= VIDEO_PT_RESET;
      audio_pt_r <= AUDIO_PT_RESET;
      body_len_r <= BODY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIM_NUMBER: sim_r      <= cfg_data;
        REG_CHANNEL:    channel_r  <= cfg_data[7:0];
        REG_VIDEO_PT:   video_pt_r <= cfg_data[6:0];
        REG_AUDIO_PT:   audio_pt_r <= cfg_data[6:0];
        REG_BODY_LEN:   body_len_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  mfrp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_is_audio       (in_is_audio),
    .in_frame_len      (in_frame_len),
    .in_frame_time     (in_frame_time),
    .in_now_ms         (in_now_ms),
    .in_nal_kind       (in_nal_kind),
    .cfg               (cfg),
    .q_full            (q_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  mfrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  mfrp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_not_empty       (q_not_empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet),
    .out_end_of_run    (out_end_of_run)
  );

`ifndef SYNTH
  // The queue is never written while full.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("command queue overflow");

  // The back end only retires a command that is present.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_not_empty)
    else $error("command queue underflow");

  // A packet can only end on the data byte that closes a request.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_end_of_packet |-> out_end_of_run)
    else $error("end of packet on a header byte");
`endif

endmodule

// File: src/mfrp_front.sv
// Front end of the packetizer: accepts frame bytes, tracks frame and packet
// state and classifies each byte into a command for the queue.
// Depends on mfrp_pkg.
module mfrp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_of_frame,
  input  logic               in_is_audio,
  input  logic [19:0]        in_frame_len,
  input  logic [31:0]        in_frame_time,
  input  logic [31:0]        in_now_ms,
  input  logic [4:0]         in_nal_kind,
  input  mfrp_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               push,
  output mfrp_pkg::cmd_t     push_cmd
);
  import mfrp_pkg::*;

  logic [15:0] serial_r, serial_nxt;
  logic [15:0] last_iframe_r, last_iframe_nxt;
  logic [15:0] last_frame_r, last_frame_nxt;
  logic [19:0] frame_left_r, frame_left_nxt;
  logic [9:0]  pkt_left_r, pkt_left_nxt;
  logic        first_pkt_r, first_pkt_nxt;
  logic [2:0]  nibble_r, nibble_nxt;
  logic        audio_r, audio_nxt;
  logic [31:0] ftime_r, ftime_nxt;
  logic [15:0] iint_r, iint_nxt;
  logic [15:0] fint_r, fint_nxt;

  logic        accept;
  logic        new_video;
  logic [15:0] now16;
  logic [9:0]  blen;
  logic        last;
  logic [9:0]  plen;
  logic        need_hdr;
  logic [9:0]  pkt_cur;
  logic [1:0]  mark;
  logic [19:0] e_frame;
  logic [9:0]  e_pkt;
  logic        e_first;
  logic        e_audio;
  logic [2:0]  e_nibble;
  logic [31:0] e_ftime;
  logic [15:0] e_iint;
  logic [15:0] e_fint;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign now16    = in_now_ms[15:0];
  assign new_video = in_first_of_frame && !in_is_audio;

  // Frame state as it stands once a first byte has latched its fields.
  always_comb begin
    e_audio  = in_first_of_frame ? in_is_audio : audio_r;
    e_frame  = in_first_of_frame ? in_frame_len : frame_left_r;
    e_ftime  = in_first_of_frame ? in_frame_time : ftime_r;
    e_pkt    = in_first_of_frame ? 10'd0 : pkt_left_r;
    e_first  = in_first_of_frame ? 1'b1 : first_pkt_r;
    e_iint   = new_video ? (now16 - last_iframe_r) : iint_r;
    e_fint   = new_video ? (now16 - last_frame_r) : fint_r;
    e_nibble = nibble_r;
    last_iframe_nxt = last_iframe_r;
    last_frame_nxt  = last_frame_r;
    if (in_first_of_frame) begin
      if (in_is_audio) begin
        e_nibble = TYPE_AUDIO;
      end else begin
        last_frame_nxt = now16;
        if (in_nal_kind == NAL_IDR || in_nal_kind == NAL_SPS) begin
          e_nibble = TYPE_I;
          last_iframe_nxt = now16;
        end else if (in_nal_kind == NAL_NON_IDR) begin
          e_nibble = TYPE_P;
        end else begin
          e_nibble = TYPE_OTHER;
        end
      end
    end
  end

  // Packet split: a zero body length acts as one.
  always_comb begin
    blen     = (cfg.body_len == 10'd0) ? 10'd1 : cfg.body_len;
    last     = e_frame <= {10'd0, blen};
    plen     = last ? e_frame[9:0] : blen;
    need_hdr = e_pkt == 10'd0;
    pkt_cur  = need_hdr ? plen : e_pkt;
    if (e_first) begin
      mark = last ? MARK_ONLY : MARK_FIRST;
    end else begin
      mark = last ? MARK_LAST : MARK_MIDDLE;
    end
  end

  // Command for the back end; bytes outside a frame are dropped.
  always_comb begin
    push = accept && (e_frame != 20'd0);
    push_cmd.data       = in_data_byte;
    push_cmd.eop        = pkt_cur == 10'd1;
    push_cmd.hdr        = need_hdr;
    push_cmd.audio      = e_audio;
    push_cmd.pt_byte    = {last, e_audio ? cfg.audio_pt : cfg.video_pt};
    push_cmd.serial     = serial_r;
    push_cmd.type_byte  = {1'b0, e_nibble, 2'b00, mark};
    push_cmd.frame_time = e_ftime;
    push_cmd.iframe_int = e_iint;
    push_cmd.frame_int  = e_fint;
    push_cmd.plen       = plen;
  end

  // Next state on an accepted byte.
  always_comb begin
    serial_nxt     = serial_r;
    frame_left_nxt = e_frame;
    pkt_left_nxt   = e_pkt;
    first_pkt_nxt  = e_first;
    nibble_nxt     = e_nibble;
    audio_nxt      = e_audio;
    ftime_nxt      = e_ftime;
    iint_nxt       = e_iint;
    fint_nxt       = e_fint;
    if (push) begin
      frame_left_nxt = e_frame - 20'd1;
      pkt_left_nxt   = pkt_cur - 10'd1;
      if (need_hdr) begin
        serial_nxt    = serial_r + 16'd1;
        first_pkt_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      serial_r      <= '0;
      last_iframe_r <= '0;
      last_frame_r  <= '0;
      frame_left_r  <= '0;
      pkt_left_r    <= '0;
      first_pkt_r   <= 1'b0;
      nibble_r      <= '0;
      audio_r       <= 1'b0;
      ftime_r       <= '0;
      iint_r        <= '0;
      fint_r        <= '0;
    end else if (accept) begin
      serial_r      <= serial_nxt;
      last_iframe_r <= last_iframe_nxt;
      last_frame_r  <= last_frame_nxt;
      frame_left_r  <= frame_left_nxt;
      pkt_left_r    <= pkt_left_nxt;
      first_pkt_r   <= first_pkt_nxt;
      nibble_r      <= nibble_nxt;
      audio_r       <= audio_nxt;
      ftime_r       <= ftime_nxt;
      iint_r        <= iint_nxt;
      fint_r        <= fint_nxt;
    end
  end

endmodule

// File: src/mfrp_queue.sv
// Short command queue between the front and back ends of the packetizer.
// Register based, one write and one read a cycle. Depends on mfrp_pkg.
module mfrp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfrp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mfrp_pkg::cmd_t head
);
  import mfrp_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full      = count_r == Q_CW'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  // Occupancy count.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/mfrp_back.sv
// Back end of the packetizer: sends the header bytes of a command that opens a packet,
// then its data byte, through a registered output stage. Depends on mfrp_pkg.
module mfrp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mfrp_pkg::cfg_t cfg,
  input  logic           q_not_empty,
  input  mfrp_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_end_of_packet,
  output logic           out_end_of_run
);
  import mfrp_pkg::*;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_eop_r, out_eop_nxt;
  logic       out_eor_r, out_eor_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       hdr_done_r, hdr_done_nxt;

  logic       load;
  logic       send_hdr;
  logic [4:0] hdr_last;
  logic [4:0] pos;
  logic [7:0] hdr_byte;

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_end_of_packet = out_eop_r;
  assign out_end_of_run    = out_eor_r;

  assign load     = !out_valid_r || out_ready;
  assign send_hdr = head.hdr && !hdr_done_r;
  assign hdr_last = head.audio ? AUDIO_HDR_LAST : VIDEO_HDR_LAST;
  // Audio headers skip the two video interval fields.
  assign pos      = (head.audio && idx_r >= TAIL_START) ? idx_r + AUDIO_SKIP : idx_r;

  // Header byte at the current position, big-endian.
  always_comb begin
    case (pos)
      5'd0:    hdr_byte = MAGIC_WORD[31:24];
      5'd1:    hdr_byte = MAGIC_WORD[23:16];
      5'd2:    hdr_byte = MAGIC_WORD[15:8];
      5'd3:    hdr_byte = MAGIC_WORD[7:0];
      5'd4:    hdr_byte = VERSION_BYTE;
      5'd5:    hdr_byte = head.pt_byte;
      5'd6:    hdr_byte = head.serial[15:8];
      5'd7:    hdr_byte = head.serial[7:0];
      5'd8:    hdr_byte = cfg.sim_number[47:40];
      5'd9:    hdr_byte = cfg.sim_number[39:32];
      5'd10:   hdr_byte = cfg.sim_number[31:24];
      5'd11:   hdr_byte = cfg.sim_number[23:16];
      5'd12:   hdr_byte = cfg.sim_number[15:8];
      5'd13:   hdr_byte = cfg.sim_number[7:0];
      5'd14:   hdr_byte = cfg.logical_channel;
      5'd15:   hdr_byte = head.type_byte;
      5'd20:   hdr_byte = head.frame_time[31:24];
      5'd21:   hdr_byte = head.frame_time[23:16];
      5'd22:   hdr_byte = head.frame_time[15:8];
      5'd23:   hdr_byte = head.frame_time[7:0];
      5'd24:   hdr_byte = head.iframe_int[15:8];
      5'd25:   hdr_byte = head.iframe_int[7:0];
      5'd26:   hdr_byte = head.frame_int[15:8];
      5'd27:   hdr_byte = head.frame_int[7:0];
      5'd28:   hdr_byte = {6'd0, head.plen[9:8]};
      5'd29:   hdr_byte = head.plen[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // Sequencing of header and data bytes.
  always_comb begin
    pop          = 1'b0;
    idx_nxt      = idx_r;
    hdr_done_nxt = hdr_done_r;
    out_byte_nxt = out_byte_r;
    out_eop_nxt  = out_eop_r;
    out_eor_nxt  = out_eor_r;
    if (load && q_not_empty) begin
      if (send_hdr) begin
        out_byte_nxt = hdr_byte;
        out_eop_nxt  = 1'b0;
        out_eor_nxt  = 1'b0;
        if (idx_r == hdr_last) begin
          idx_nxt      = '0;
          hdr_done_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end else begin
        out_byte_nxt = head.data;
        out_eop_nxt  = head.eop;
        out_eor_nxt  = 1'b1;
        hdr_done_nxt = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hdr_done_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= q_not_empty;
      end
      idx_r      <= idx_nxt;
      hdr_done_r <= hdr_done_nxt;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_eop_r  <= out_eop_nxt;
    out_eor_r  <= out_eor_nxt;
  end

endmodule

// File: tb/media_frame_rtp_packetizer_tb.sv
// Self-checking testbench for media_frame_rtp_packetizer: drives byte requests and register
// writes, predicts every header and payload byte, and compares the output stream in order.
// Depends on mfrp_pkg and the packetizer RTL.
module media_frame_rtp_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfrp_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 48;

  // One byte of the packet stream with its two flags.
  typedef struct packed {
    logic [7:0] value;
    logic       eop;
    logic       eor;
  } stream_byte_t;

  // Packet stream predictor plus the queue of bytes still owed by the block.
  class packet_scoreboard;
    logic [47:0] sim_number_r;
    logic [7:0]  channel_r;
    logic [6:0]  video_pt_r;
    logic [6:0]  audio_pt_r;
    logic [9:0]  body_len_r;
    logic [15:0] serial;
    logic [15:0] last_iframe_ms;
    logic [15:0] last_frame_ms;
    logic [15:0] iframe_gap;
    logic [15:0] frame_gap;
    logic [19:0] frame_left;
    logic [9:0]  packet_left;
    logic        opening_packet;
    logic [2:0]  type_code;
    logic        audio_frame;
    logic [31:0] frame_stamp;
    stream_byte_t pending_bytes[$];
    int errors;
    int frames;
    int packets;
    int results;

    function new();
      sim_number_r   = SIM_RESET;
      channel_r      = CHANNEL_RESET;
      video_pt_r     = VIDEO_PT_RESET;
      audio_pt_r     = AUDIO_PT_RESET;
      body_len_r     = BODY_LEN_RESET;
      serial         = '0;
      last_iframe_ms = '0;
      last_frame_ms  = '0;
      iframe_gap     = '0;
      frame_gap      = '0;
      frame_left     = '0;
      packet_left    = '0;
      opening_packet = 1'b0;
      type_code      = '0;
      audio_frame    = 1'b0;
      frame_stamp    = '0;
      errors         = 0;
      frames         = 0;
      packets        = 0;
      results        = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SIM_NUMBER: sim_number_r = val[47:0];
        REG_CHANNEL:    channel_r    = val[7:0];
        REG_VIDEO_PT:   video_pt_r   = val[6:0];
        REG_AUDIO_PT:   audio_pt_r   = val[6:0];
        REG_BODY_LEN:   body_len_r   = val[9:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] b);
      pending_bytes.push_back('{b, 1'b0, 1'b0});
    endfunction

    function void push_word16(logic [15:0] w);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
    endfunction

    function void push_word32(logic [31:0] w);
      push_word16(w[31:16]);
      push_word16(w[15:0]);
    endfunction

    // Predicts the bytes caused by one accepted request; returns how many.
    function int note_request(logic [7:0] data, logic first, logic audio, logic [19:0] flen,
                              logic [31:0] ftime, logic [31:0] now, logic [4:0] nal);
      int start_size;
      logic [15:0] now16;
      logic [9:0] blen;
      logic [9:0] plen;
      logic last;
      logic [6:0] pt;
      logic [1:0] mark;
      start_size = pending_bytes.size();
      now16 = now[15:0];
      // A first byte latches the frame fields and, for video, the timing gaps.
      if (first) begin
        frames++;
        audio_frame    = audio;
        frame_left     = flen;
        frame_stamp    = ftime;
        packet_left    = '0;
        opening_packet = 1'b1;
        if (audio) begin
          type_code = TYPE_AUDIO;
        end else begin
          iframe_gap = now16 - last_iframe_ms;
          frame_gap  = now16 - last_frame_ms;
          if (nal == NAL_IDR || nal == NAL_SPS) begin
            type_code      = TYPE_I;
            last_iframe_ms = now16;
          end else if (nal == NAL_NON_IDR) begin
            type_code = TYPE_P;
          end else begin
            type_code = TYPE_OTHER;
          end
          last_frame_ms = now16;
        end
      end
      if (frame_left == 0) return 0;
      // A byte that opens a packet is preceded by the full header.
      if (packet_left == 0) begin
        blen = (body_len_r == 0) ? 10'd1 : body_len_r;
        last = (frame_left <= {10'd0, blen});
        plen = last ? frame_left[9:0] : blen;
        pt   = audio_frame ? audio_pt_r : video_pt_r;
        if (opening_packet) mark = last ? MARK_ONLY : MARK_FIRST;
        else mark = last ? MARK_LAST : MARK_MIDDLE;
        push_word32(MAGIC_WORD);
        push_byte(VERSION_BYTE);
        push_byte({last, pt});
        push_word16(serial);
        for (int i = 5; i >= 0; i--) push_byte(sim_number_r[8*i +: 8]);
        push_byte(channel_r);
        push_byte({1'b0, type_code, 2'b00, mark});
        push_word32(32'd0);
        push_word32(frame_stamp);
        if (!audio_frame) begin
          push_word16(iframe_gap);
          push_word16(frame_gap);
        end
        push_word16({6'd0, plen});
        serial         = serial + 16'd1;
        opening_packet = 1'b0;
        packet_left    = plen;
        packets++;
      end
      packet_left = packet_left - 10'd1;
      frame_left  = frame_left - 20'd1;
      pending_bytes.push_back('{data, packet_left == 0, 1'b1});
      return pending_bytes.size() - start_size;
    endfunction

    // Compares one accepted output byte with the oldest prediction.
    function void check_result(logic [7:0] b, logic eop, logic eor);
      stream_byte_t e;
      results++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h end_of_packet %0b end_of_run %0b", b, eop, eor);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      if (b !== e.value) begin
        $error("out_byte: expected %02h actual %02h", e.value, b);
        errors++;
      end
      if (eop !== e.eop) begin
        $error("end_of_packet: expected %0b actual %0b", e.eop, eop);
        errors++;
      end
      if (eor !== e.eor) begin
        $error("end_of_run: expected %0b actual %0b", e.eor, eor);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic                  in_first_of_frame;
  logic                  in_is_audio;
  logic [19:0]           in_frame_len;
  logic [31:0]           in_frame_time;
  logic [31:0]           in_now_ms;
  logic [4:0]            in_nal_kind;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  out_end_of_packet;
  logic                  out_end_of_run;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  packet_scoreboard sb;
  int               cycle_count = 0;
  int               payload_items = 0;
  bit               calm = 1'b0;
  logic [31:0]      media_clock;

  media_frame_rtp_packetizer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_is_audio       (in_is_audio),
    .in_frame_len      (in_frame_len),
    .in_frame_time     (in_frame_time),
    .in_now_ms         (in_now_ms),
    .in_nal_kind       (in_nal_kind),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet),
    .out_end_of_run    (out_end_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sample both channels before the edge updates them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (sb.note_request(in_data_byte, in_first_of_frame, in_is_audio, in_frame_len,
                            in_frame_time, in_now_ms, in_nal_kind) > 0) begin
          payload_items <= payload_items + 1;
        end
      end
      if (out_valid && out_ready) sb.check_result(out_byte, out_end_of_packet, out_end_of_run);
    end
  end

  // Receiver back-pressure in random bursts, off once the run turns calm.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send_byte(logic [7:0] data, logic first, logic audio, logic [19:0] flen,
                           logic [31:0] ftime, logic [31:0] now, logic [4:0] nal);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_first_of_frame <= first;
    in_is_audio       <= audio;
    in_frame_len      <= flen;
    in_frame_time     <= ftime;
    in_now_ms         <= now;
    in_nal_kind       <= nal;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sends count bytes of a frame that declares flen bytes; later bytes carry junk fields.
  task automatic send_frame(logic [19:0] flen, int count, logic audio, logic [4:0] nal,
                            logic [31:0] ftime, logic [31:0] now);
    for (int k = 0; k < count; k++) begin
      if (k == 0) send_byte(8'($urandom), 1'b1, audio, flen, ftime, now, nal);
      else send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 20'($urandom), $urandom,
                     $urandom, 5'($urandom));
    end
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(logic [47:0] sim, logic [7:0] chan, logic [6:0] vpt,
                              logic [6:0] apt, logic [9:0] blen);
    write_cfg(REG_SIM_NUMBER, sim);
    write_cfg(REG_CHANNEL, {40'd0, chan});
    write_cfg(REG_VIDEO_PT, {41'd0, vpt});
    write_cfg(REG_AUDIO_PT, {41'd0, apt});
    write_cfg(REG_BODY_LEN, {38'd0, blen});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Drain, then give dropped requests time to leave the pipeline.
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_nal();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return NAL_IDR;
    if (r == 3) return NAL_SPS;
    if (r < 7) return NAL_NON_IDR;
    return 5'($urandom_range(0, 31));
  endfunction

  // Random traffic: mostly whole frames, plus cut frames, stray bytes and empty frames.
  task automatic run_frames(int quota);
    int target;
    int r;
    int flen;
    target = payload_items + quota;
    while (payload_items < target) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) media_clock = $urandom;
      else media_clock = media_clock + $urandom_range(1, 3000);
      if (r < 78) begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_frame(20'(flen), flen, 1'($urandom_range(0, 1)), pick_nal(), $urandom,
                   media_clock);
      end else if (r < 88) begin
        send_frame(20'($urandom_range(1, 20'hFFFFF)), $urandom_range(1, 4),
                   1'($urandom_range(0, 1)), pick_nal(), $urandom, media_clock);
      end else if (r < 94) begin
        send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 20'($urandom), $urandom,
                  $urandom, 5'($urandom));
      end else begin
        send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)), 20'd0, $urandom, media_clock,
                  pick_nal());
      end
      if (!calm && $urandom_range(0, 24) == 0) wait_for_results();
    end
  endtask

  // Main sequence: reset, directed cases, then random phases under several settings.
  initial begin
    sb = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = '0;
    in_first_of_frame = 1'b0;
    in_is_audio       = 1'b0;
    in_frame_len      = '0;
    in_frame_time     = '0;
    in_now_ms         = '0;
    in_nal_kind       = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    media_clock       = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a stray byte outside any frame, then a short I frame.
    send_byte(8'hFF, 1'b0, 1'b1, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F);
    send_byte(8'h00, 1'b1, 1'b0, 20'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NAL_IDR);
    send_byte(8'hFF, 1'b0, 1'b0, 20'd0, 32'd0, 32'd0, 5'd0);
    settle();

    // Zero body length behaves as one byte per packet; audio ignores the NAL kind.
    program_regs(48'hFFFF_FFFF_FFFF, 8'hFF, 7'd0, 7'h7F, 10'd0);
    send_frame(20'd2, 2, 1'b1, NAL_SPS, 32'h1234_5678, 32'h0000_8000);
    send_byte(8'h5A, 1'b1, 1'b0, 20'd0, 32'd7, 32'h0001_0010, NAL_NON_IDR);
    settle();

    // Multi-packet P frame, SPS frame, other kind, then a huge frame cut by an audio frame.
    program_regs(48'h0139_2468_1357, 8'h00, VIDEO_PT_RESET, AUDIO_PT_RESET, 10'd3);
    send_frame(20'd7, 7, 1'b0, NAL_NON_IDR, 32'hA5A5_0001, 32'h0000_0100);
    send_frame(20'd2, 2, 1'b0, NAL_SPS, 32'h0000_0002, 32'h0000_FFF0);
    send_frame(20'd1, 1, 1'b0, 5'd0, 32'h0000_0003, 32'h0001_0005);
    send_frame(20'hFFFFF, 2, 1'b0, 5'h1F, 32'h8000_0000, 32'h0002_0000);
    send_frame(20'd3, 3, 1'b1, NAL_IDR, 32'h0000_0004, 32'h0002_0040);
    settle();

    program_regs(48'({$urandom, $urandom}), 8'($urandom), 7'($urandom), 7'($urandom),
                 10'($urandom_range(1, 8)));
    run_frames(55);
    settle();

    program_regs(48'd0, CHANNEL_RESET, 7'h7F, 7'd0, 10'd1023);
    run_frames(40);
    settle();

    program_regs(48'({$urandom, $urandom}), 8'($urandom), 7'($urandom), 7'($urandom),
                 10'($urandom_range(2, 5)));
    run_frames(50);
    settle();

    // Closing phase without any idling on either side.
    calm = 1'b1;
    program_regs(48'({$urandom, $urandom}), 8'($urandom), 7'($urandom), 7'($urandom),
                 10'($urandom_range(1, 6)));
    run_frames(45);
    settle();

    if (sb.pending_bytes.size() != 0) begin
      $error("%0d predicted bytes never arrived", sb.pending_bytes.size());
      sb.errors++;
    end
    $display("Covered %0d frames and %0d packets across seven register settings,", sb.frames,
             sb.packets);
    $display("with %0d output bytes compared and %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: media_frame_rtp_packetizer.f
src/mfrp_pkg.sv
src/mfrp_front.sv
src/mfrp_queue.sv
src/mfrp_back.sv
src/media_frame_rtp_packetizer.sv
tb/media_frame_rtp_packetizer_tb.sv
